/* sv/sal_pkg.sv */
package sal_pkg;

    // fixed field widths
    localparam int MAC_W      = 48;
    localparam int CTR_W      = 32;
    localparam int SLOT_W     = 3;
    localparam int LEARN_W    = 4;
    localparam int STOP_W     = 4;

    // table size default
    localparam int TABLE_DEPTH_DEFAULT = 8;

    // register file
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_STOP_COUNT = 1'b0;
    localparam logic [STOP_W-1:0] STOP_COUNT_RESET = 4'd6;

    // destination that marks a broadcast frame
    localparam logic [MAC_W-1:0] MAC_BROADCAST = '1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } sal_state_t;

endpackage

/* sv/sal_ram.sv */
module sal_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/station_address_learner.sv */
// Station address learner. Each item is one frame header (destination and
// source address). The block counts frames and broadcast frames (both
// saturating at 2^32-1), looks the source address up in a table of learned
// stations and appends it when new, unless the table is full. Once the
// learned count reaches stop_count (APB register 0, reset 6) every further
// frame is answered with done_res set and changes nothing. The item is
// taken in ST_IDLE, then ST_SCAN compares one table entry per cycle, and no
// new item is taken until the result is registered; the table sits in a RAM
// with one write and one read port that one 48-bit comparator walks.
// Frames after done skip the walk. A result waiting at the output does not
// block the next item, but the next result is held back until it is taken.
module station_address_learner
    import sal_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MAC_W-1:0]      s_dest_mac,
    input  logic [MAC_W-1:0]      s_src_mac,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_is_broadcast,
    output logic                  m_is_new_station,
    output logic [SLOT_W-1:0]     m_station_slot,
    output logic [LEARN_W-1:0]    m_learned_count,
    output logic [CTR_W-1:0]      m_frames_seen,
    output logic [CTR_W-1:0]      m_broadcasts_seen,
    output logic                  m_done_res
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > STOP_W) ? CNT_W : STOP_W;
    localparam logic [CNT_W-1:0] TOTAL_FULL = CNT_W'(TABLE_DEPTH);

    sal_state_t state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [MAC_W-1:0]   dst_reg, dst_next;
    logic [MAC_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CTR_W-1:0]   frames_reg, frames_next;
    logic [CTR_W-1:0]   bcasts_reg, bcasts_next;
    logic [STOP_W-1:0]  stop_reg, stop_next;

    logic               m_valid_reg, m_valid_next;
    logic               bcast_out_reg, bcast_out_next;
    logic               new_out_reg, new_out_next;
    logic [SLOT_W-1:0]  slot_out_reg, slot_out_next;
    logic               done_out_reg, done_out_next;

    logic               accept;
    logic               out_free;
    logic               done_now;
    logic               hit;
    logic               more;
    logic               resolved;
    logic               finish;
    logic               full;
    logic               cfg_wr;
    logic               tbl_we;
    logic [MAC_W-1:0]   rd_data;
    logic [CNT_W-1:0]   idx_ext;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_STOP_COUNT);
    assign stop_next = cfg_wr ? pwdata[STOP_W-1:0] : stop_reg;
    assign prdata = (paddr[2:2] == REG_STOP_COUNT) ?
                    CFG_DATA_W'(stop_reg) : '0;

    // handshake
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // shared compare step over the table
    assign idx_ext  = CNT_W'(idx_reg);
    assign done_now = CMP_W'(total_reg) >= CMP_W'(stop_reg);
    assign hit      = (idx_ext < total_reg) && (rd_data == src_reg);
    assign more     = (CNT_W'(idx_ext + 1'b1) < total_reg) && (idx_ext < total_reg);
    assign resolved = done_now || hit || !more;
    assign finish   = (state_reg == ST_SCAN) && resolved && out_free;
    assign full     = (total_reg == TOTAL_FULL);
    assign tbl_we   = finish && !done_now && !hit && !full;

    sal_ram #(
        .WIDTH (MAC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (total_reg[IDX_W-1:0]),
        .wdata (src_reg),
        .raddr (idx_next),
        .rdata (rd_data)
    );

    // sequencer next state and scan index
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!resolved) begin
                    idx_next = IDX_W'(idx_ext + 1'b1);
                end else if (out_free) begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    // item latch, totals and result register
    always_comb begin
        dst_next       = dst_reg;
        src_next       = src_reg;
        total_next     = total_reg;
        frames_next    = frames_reg;
        bcasts_next    = bcasts_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        bcast_out_next = bcast_out_reg;
        new_out_next   = new_out_reg;
        slot_out_next  = slot_out_reg;
        done_out_next  = done_out_reg;

        if (accept) begin
            dst_next = s_dest_mac;
            src_next = s_src_mac;
        end

        if (finish) begin
            m_valid_next   = 1'b1;
            bcast_out_next = 1'b0;
            new_out_next   = 1'b0;
            slot_out_next  = '0;
            done_out_next  = done_now;
            if (!done_now) begin
                // saturating frame counters
                if (frames_reg != '1) begin
                    frames_next = frames_reg + 1'b1;
                end
                if (dst_reg == MAC_BROADCAST) begin
                    bcast_out_next = 1'b1;
                    if (bcasts_reg != '1) begin
                        bcasts_next = bcasts_reg + 1'b1;
                    end
                end
                // found, appended, or dropped when the table is full
                if (hit) begin
                    slot_out_next = SLOT_W'(idx_reg);
                end else if (!full) begin
                    slot_out_next = SLOT_W'(total_reg);
                    new_out_next  = 1'b1;
                    total_next    = total_reg + 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            total_reg   <= '0;
            frames_reg  <= '0;
            bcasts_reg  <= '0;
            stop_reg    <= STOP_COUNT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            total_reg   <= total_next;
            frames_reg  <= frames_next;
            bcasts_reg  <= bcasts_next;
            stop_reg    <= stop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dst_reg       <= dst_next;
        src_reg       <= src_next;
        bcast_out_reg <= bcast_out_next;
        new_out_reg   <= new_out_next;
        slot_out_reg  <= slot_out_next;
        done_out_reg  <= done_out_next;
    end

    // result ports; totals track the registers, which only move on finish
    assign m_valid           = m_valid_reg;
    assign m_is_broadcast    = bcast_out_reg;
    assign m_is_new_station  = new_out_reg;
    assign m_station_slot    = slot_out_reg;
    assign m_learned_count   = LEARN_W'(total_reg);
    assign m_frames_seen     = frames_reg;
    assign m_broadcasts_seen = bcasts_reg;
    assign m_done_res        = done_out_reg;

endmodule
